// File: hdl/grr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grr_pkg: shared definitions for the glyph row renderer
// Sizes, register indexes, request codes, attribute bit positions and the
// types that pass between the sequencer and the font memory.
// ----------------------------------------------------------------------------
package grr_pkg;

   // Font memory geometry.
   localparam int FONT_BITS   = 32768;
   localparam int FONT_AW     = 15;

   // Screen geometry.
   localparam logic [9:0] SCREEN_W = 10'd640;
   localparam logic [9:0] SCREEN_H = 10'd480;

   // Glyph limits: one row of lanes, up to sixteen rows.
   localparam int NUM_LANES = 8;
   localparam int COLOR_W   = 4;
   localparam logic [3:0] LANE_CAP = 4'd8;
   localparam logic [4:0] MAX_H    = 5'd16;

   // Configuration register indexes.
   localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd0;
   localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd1;
   localparam logic [2:0] REG_FG_COLOR     = 3'd2;
   localparam logic [2:0] REG_BG_COLOR     = 3'd3;
   localparam logic [2:0] REG_ATTR_FLAGS   = 3'd4;

   // Register reset values.
   localparam logic [3:0] RST_GLYPH_WIDTH  = 4'd8;
   localparam logic [4:0] RST_GLYPH_HEIGHT = 5'd16;
   localparam logic [3:0] RST_FG_COLOR     = 4'd7;
   localparam logic [3:0] RST_BG_COLOR     = 4'd0;
   localparam logic [6:0] RST_ATTR_FLAGS   = 7'd0;

   // Request codes.
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_DRAW = 1'b1;

   // Attribute flag bit positions.
   localparam int ATTR_HFLIP  = 0;
   localparam int ATTR_VFLIP  = 1;
   localparam int ATTR_ROTCW  = 2;
   localparam int ATTR_ROTCCW = 3;
   localparam int ATTR_REV    = 4;
   localparam int ATTR_MASKED = 5;
   localparam int ATTR_NODRAW = 6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic               en;
      logic [FONT_AW-1:0] addr;
      logic               data;
   } font_wr_type;

   typedef struct packed {
      logic               en;
      logic [FONT_AW-1:0] addr;
   } font_rd_type;

endpackage

// File: hdl/glyph_row_renderer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_row_renderer_top: bitmap font glyph renderer
// A load writes one font bit and never raises busy.
// A draw of a w x h glyph keeps busy high through a setup state, then one
// pixel per cycle through the single read port of the font memory, then a
// flush state. Each row leaves the result registers after its last pixel
// is read. Results cannot be stalled; each row is a one-cycle beat.
// Reset returns the registers to their defaults and idles the sequencer;
// the font memory keeps its contents.
// ----------------------------------------------------------------------------
module glyph_row_renderer_top (
   input  logic        clock,
   input  logic        reset,
   // Requests
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [14:0] req_font_addr,
   input  logic        req_font_bit,
   input  logic [7:0]  req_char_code,
   input  logic [9:0]  req_pos_x,
   input  logic [8:0]  req_pos_y,
   // Row results
   output logic        rsp_valid,
   output logic [9:0]  rsp_row_x,
   output logic [8:0]  rsp_row_y,
   output logic [31:0] rsp_row_colors,
   output logic [7:0]  rsp_row_write_mask,
   output logic        rsp_last_row,
   // Register writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   // Configuration registers.
   logic [3:0] glyph_width_ff;
   logic [4:0] glyph_height_ff;
   logic [3:0] fg_color_ff;
   logic [3:0] bg_color_ff;
   logic [6:0] attr_flags_ff;

   grr_pkg::state_type state_ff, state_in;

   // Per-draw registers.
   logic [7:0]  code_ff;
   logic [9:0]  row_x_ff;
   logic [8:0]  pos_y_ff;
   logic [3:0]  w_ff;
   logic [4:0]  h_ff;
   logic [7:0]  wh_ff;
   logic [14:0] base_ff;
   logic [2:0]  cx_ff;
   logic [3:0]  cy_ff;

   // Read pipeline: what the pixel in flight belongs to.
   logic        p_valid_ff;
   logic [2:0]  p_cx_ff;
   logic [3:0]  p_cy_ff;
   logic        p_row_end_ff;
   logic        p_last_ff;

   // Row assembly and result registers.
   logic [31:0] acc_colors_ff;
   logic [7:0]  acc_mask_ff;
   logic        rsp_valid_ff;
   logic [9:0]  rsp_row_x_ff;
   logic [8:0]  rsp_row_y_ff;
   logic [31:0] rsp_colors_ff;
   logic [7:0]  rsp_mask_ff;
   logic        rsp_last_ff;

   logic        accept;
   logic        draw_go;
   logic        issue;
   logic [3:0]  w_sat;
   logic [4:0]  h_sat;
   logic [2:0]  w_last;
   logic [3:0]  h_last;
   logic        pix_row_end;
   logic        pix_last;
   logic [9:0]  pos_x_wrap;

   grr_pkg::font_wr_type font_wr;
   grr_pkg::font_rd_type font_rd;
   logic                 rd_bit;

   // ---------------------------------------------------------------------
   // Register writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_width_ff  <= grr_pkg::RST_GLYPH_WIDTH;
         glyph_height_ff <= grr_pkg::RST_GLYPH_HEIGHT;
         fg_color_ff     <= grr_pkg::RST_FG_COLOR;
         bg_color_ff     <= grr_pkg::RST_BG_COLOR;
         attr_flags_ff   <= grr_pkg::RST_ATTR_FLAGS;
      end else if (csr_we) begin
         case (csr_index)
            grr_pkg::REG_GLYPH_WIDTH:  glyph_width_ff  <= csr_wdata[3:0];
            grr_pkg::REG_GLYPH_HEIGHT: glyph_height_ff <= csr_wdata[4:0];
            grr_pkg::REG_FG_COLOR:     fg_color_ff     <= csr_wdata[3:0];
            grr_pkg::REG_BG_COLOR:     bg_color_ff     <= csr_wdata[3:0];
            grr_pkg::REG_ATTR_FLAGS:   attr_flags_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Request acceptance
   // ---------------------------------------------------------------------
   assign w_sat = (glyph_width_ff > grr_pkg::LANE_CAP) ? grr_pkg::LANE_CAP : glyph_width_ff;
   assign h_sat = (glyph_height_ff > grr_pkg::MAX_H) ? grr_pkg::MAX_H : glyph_height_ff;

   assign accept  = start && !busy;
   // A zero-sized glyph gives no rows, so the draw is taken and dropped.
   assign draw_go = accept && (req_type == grr_pkg::REQ_DRAW)
                    && (w_sat != 4'd0) && (h_sat != 5'd0);

   assign pos_x_wrap = (req_pos_x >= grr_pkg::SCREEN_W) ? req_pos_x - grr_pkg::SCREEN_W
                                                         : req_pos_x;

   assign font_wr.en   = accept && (req_type == grr_pkg::REQ_LOAD);
   assign font_wr.addr = req_font_addr;
   assign font_wr.data = req_font_bit;

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   assign w_last      = 3'(w_ff - 4'd1);
   assign h_last      = 4'(h_ff - 5'd1);
   assign pix_row_end = (cx_ff == w_last);
   assign pix_last    = pix_row_end && (cy_ff == h_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      busy     = 1'b1;
      issue    = 1'b0;
      case (state_ff)
         grr_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (draw_go) begin
               state_in = grr_pkg::ST_SETUP;
            end
         end
         grr_pkg::ST_SETUP: begin
            state_in = grr_pkg::ST_RUN;
         end
         grr_pkg::ST_RUN: begin
            issue = 1'b1;
            if (pix_last) begin
               state_in = grr_pkg::ST_FLUSH;
            end
         end
         grr_pkg::ST_FLUSH: begin
            // The last pixel's row is being closed out this cycle.
            state_in = grr_pkg::ST_IDLE;
         end
         default: begin
            state_in = grr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (draw_go) begin
         code_ff  <= req_char_code;
         row_x_ff <= pos_x_wrap;
         pos_y_ff <= req_pos_y;
         w_ff     <= w_sat;
         h_ff     <= h_sat;
         wh_ff    <= 8'(w_sat * h_sat);
      end
      if (state_ff == grr_pkg::ST_SETUP) begin
         base_ff <= 15'(code_ff * wh_ff);
         cx_ff   <= '0;
         cy_ff   <= '0;
      end else if (issue) begin
         if (pix_row_end) begin
            cx_ff <= '0;
            cy_ff <= 4'(cy_ff + 4'd1);
         end else begin
            cx_ff <= 3'(cx_ff + 3'd1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Source pixel address: flips, then clockwise, then counter-clockwise.
   // Coordinates may leave the glyph; the low bits of the two's-complement
   // sum give the nonnegative remainder modulo the memory size.
   // ---------------------------------------------------------------------
   logic signed [6:0]  w_s, h_s, cx_s, cy_s;
   logic signed [6:0]  fx, fy, rx, ry, sx, sy;
   logic signed [13:0] sy_w;
   logic signed [15:0] addr_sum;

   always_comb begin
      w_s  = $signed({3'b000, w_ff});
      h_s  = $signed({2'b00, h_ff});
      cx_s = $signed({4'b0000, cx_ff});
      cy_s = $signed({3'b000, cy_ff});
      fx   = attr_flags_ff[grr_pkg::ATTR_HFLIP] ? w_s - 7'sd1 - cx_s : cx_s;
      fy   = attr_flags_ff[grr_pkg::ATTR_VFLIP] ? h_s - 7'sd1 - cy_s : cy_s;
      if (attr_flags_ff[grr_pkg::ATTR_ROTCW]) begin
         rx = fy;
         ry = w_s - 7'sd1 - fx;
      end else begin
         rx = fx;
         ry = fy;
      end
      if (attr_flags_ff[grr_pkg::ATTR_ROTCCW]) begin
         sx = h_s - 7'sd1 - ry;
         sy = rx;
      end else begin
         sx = rx;
         sy = ry;
      end
      sy_w     = sy * w_s;
      addr_sum = $signed({1'b0, base_ff}) + 16'(sx) + 16'(sy_w);
   end

   assign font_rd.en   = issue;
   assign font_rd.addr = addr_sum[grr_pkg::FONT_AW-1:0];

   grr_font_ram u_font_ram (
      .clock  (clock),
      .wr     (font_wr),
      .rd     (font_rd),
      .rd_bit (rd_bit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= issue;
      end
      p_cx_ff      <= cx_ff;
      p_cy_ff      <= cy_ff;
      p_row_end_ff <= pix_row_end;
      p_last_ff    <= pix_last;
   end

   // ---------------------------------------------------------------------
   // Pixel colour and row assembly
   // ---------------------------------------------------------------------
   logic [3:0]  set_col;
   logic [3:0]  lane_col;
   logic        lane_wr;
   logic [31:0] row_colors;
   logic [7:0]  row_mask;
   logic [9:0]  y_sum;
   logic [8:0]  y_wrap;

   assign set_col = attr_flags_ff[grr_pkg::ATTR_REV] ? 4'(4'hF - code_ff[3:0]) : fg_color_ff;

   always_comb begin
      lane_col = bg_color_ff;
      lane_wr  = 1'b1;
      if (attr_flags_ff[grr_pkg::ATTR_NODRAW]) begin
         lane_col = bg_color_ff;
      end else if (rd_bit) begin
         lane_col = set_col;
      end else if (attr_flags_ff[grr_pkg::ATTR_MASKED] && (bg_color_ff == 4'd0)) begin
         lane_col = 4'd0;
         lane_wr  = 1'b0;
      end
      row_colors = acc_colors_ff;
      row_mask   = acc_mask_ff;
      if (lane_wr) begin
         row_colors = acc_colors_ff | (32'(lane_col) << {p_cx_ff, 2'b00});
         row_mask   = acc_mask_ff | (8'd1 << p_cx_ff);
      end
      y_sum  = {1'b0, pos_y_ff} + {6'd0, p_cy_ff};
      y_wrap = (y_sum >= grr_pkg::SCREEN_H) ? 9'(y_sum - grr_pkg::SCREEN_H) : y_sum[8:0];
   end

   always_ff @(posedge clock) begin
      if (state_ff == grr_pkg::ST_SETUP) begin
         acc_colors_ff <= '0;
         acc_mask_ff   <= '0;
      end else if (p_valid_ff) begin
         if (p_row_end_ff) begin
            acc_colors_ff <= '0;
            acc_mask_ff   <= '0;
         end else begin
            acc_colors_ff <= row_colors;
            acc_mask_ff   <= row_mask;
         end
      end
      if (p_valid_ff && p_row_end_ff) begin
         rsp_row_x_ff  <= row_x_ff;
         rsp_row_y_ff  <= y_wrap;
         rsp_colors_ff <= row_colors;
         rsp_mask_ff   <= row_mask;
         rsp_last_ff   <= p_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= p_valid_ff && p_row_end_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_row_x          = rsp_row_x_ff;
   assign rsp_row_y          = rsp_row_y_ff;
   assign rsp_row_colors     = rsp_colors_ff;
   assign rsp_row_write_mask = rsp_mask_ff;
   assign rsp_last_row       = rsp_last_ff;

endmodule

// File: hdl/grr_font_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grr_font_ram: one-bit-wide font memory
// One write port and one read port; the read data is registered, so it is
// valid in the cycle after the address. Contents are not cleared by reset.
// ----------------------------------------------------------------------------
module grr_font_ram (
   input  logic                 clock,
   input  grr_pkg::font_wr_type wr,
   input  grr_pkg::font_rd_type rd,
   output logic                 rd_bit
);

   logic mem [grr_pkg::FONT_BITS];
   logic rd_bit_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_bit_ff <= mem[rd.addr];
      end
   end

   assign rd_bit = rd_bit_ff;

endmodule

// File: hdl/grr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grr_checker: port-level checks for the glyph row renderer
// Watches the request, result and busy ports and flags beats that break
// the block's sequencing rules.
// ----------------------------------------------------------------------------
module grr_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_type,
   input logic       rsp_valid,
   input logic [9:0] rsp_row_x,
   input logic [8:0] rsp_row_y,
   input logic       rsp_last_row
);

   // More rows of the glyph are still coming, so the block must stay busy.
   a_mid_row_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_row |-> busy)
      else $error("row beat before the last one while not busy");

   // The final row goes out as the block returns to idle.
   a_last_row_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_row |-> !busy)
      else $error("last row beat while still busy");

   // A font load never occupies the block.
   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_type == grr_pkg::REQ_LOAD) |=> !busy)
      else $error("font load made the block busy");

   // Two idle cycles in a row mean no draw is left to deliver.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy ##1 !busy |-> !rsp_valid)
      else $error("row beat without a draw in progress");

   a_coords_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row_x < grr_pkg::SCREEN_W) && ({1'b0, rsp_row_y} < grr_pkg::SCREEN_H))
      else $error("row coordinates off screen");

endmodule

bind glyph_row_renderer_top grr_checker u_grr_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_type     (req_type),
   .rsp_valid    (rsp_valid),
   .rsp_row_x    (rsp_row_x),
   .rsp_row_y    (rsp_row_y),
   .rsp_last_row (rsp_last_row)
);
